// ===== design/door_stepper_half_step_driver_unit_macros.svh =====
// Assertion macros for the door stepper half-step driver.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef DOOR_STEPPER_HALF_STEP_DRIVER_UNIT_MACROS_SVH
`define DOOR_STEPPER_HALF_STEP_DRIVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define DSTEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DSTEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dstep_pkg.sv =====
// Shared types and constants for the door stepper half-step driver.
// No dependencies.
`default_nettype none

package dstep_pkg;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_TICK  = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  localparam int unsigned AddrWidth = 3;
  localparam logic REG_STEP_COUNT = 1'b0;
  localparam logic REG_AUTO_CLOSE = 1'b1;

  localparam logic [14:0] STEP_COUNT_RST = 15'd2490;  // 220 deg * 4076 / 360
  localparam logic [15:0] AUTO_CLOSE_RST = 16'd60;

  typedef struct packed {
    logic [14:0] step_count;
    logic [15:0] auto_close_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_seconds;
    logic        standby;
  } item_t;

  typedef struct packed {
    logic [3:0]        coils;
    logic              busy_res;
    logic              door_is_open;
    logic signed [15:0] steps_left;
  } res_t;

  // Eight-phase half-step coil order.
  function automatic logic [3:0] half_step_coils(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/dstep_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
// No dependencies.
`default_nettype none

interface dstep_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_seconds;
  logic        standby;

  modport source (output valid, operation, now_seconds, standby, input ready);
  modport sink (input valid, operation, now_seconds, standby, output ready);
endinterface

interface dstep_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coils;
  logic               busy_res;
  logic               door_is_open;
  logic signed [15:0] steps_left;

  modport source (output valid, coils, busy_res, door_is_open, steps_left, input ready);
  modport sink (input valid, coils, busy_res, door_is_open, steps_left, output ready);
endinterface

`default_nettype wire

// ===== design/dstep_apb.sv =====
// APB configuration registers: step_count at 0x0, auto_close_seconds at 0x4.
// Depends on dstep_pkg.
`default_nettype none

module dstep_apb (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [dstep_pkg::AddrWidth-1:0] cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready,
  output dstep_pkg::cfg_t                     cfg
);

  dstep_pkg::cfg_t cfg_r, cfg_nxt;
  logic            wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        dstep_pkg::REG_STEP_COUNT: cfg_nxt.step_count = cfg_pwdata[14:0];
        dstep_pkg::REG_AUTO_CLOSE: cfg_nxt.auto_close_seconds = cfg_pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_count         <= dstep_pkg::STEP_COUNT_RST;
      cfg_r.auto_close_seconds <= dstep_pkg::AUTO_CLOSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      dstep_pkg::REG_STEP_COUNT: cfg_prdata = {17'd0, cfg_r.step_count};
      dstep_pkg::REG_AUTO_CLOSE: cfg_prdata = {16'd0, cfg_r.auto_close_seconds};
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/dstep_seq.sv =====
// Door and motor state with the per-item update and coil table lookup.
// Depends on dstep_pkg and the assertion macro header.
`default_nettype none
`include "door_stepper_half_step_driver_unit_macros.svh"

module dstep_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  dstep_pkg::item_t      item,
  input  dstep_pkg::cfg_t       cfg,
  output dstep_pkg::res_t       res
);

  logic signed [15:0] rem_r, rem_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic               moving_r, moving_nxt;
  logic               door_open_r, door_open_nxt;
  logic [31:0]        opened_at_r, opened_at_nxt;
  logic [3:0]         coil_r, coil_nxt;

  logic [31:0]        elapsed;
  logic               do_close;
  logic signed [15:0] full_cnt;

  assign full_cnt = signed'({1'b0, cfg.step_count});
  assign elapsed  = item.now_seconds - opened_at_r;

  always_comb begin
    rem_nxt       = rem_r;
    phase_nxt     = phase_r;
    moving_nxt    = moving_r;
    door_open_nxt = door_open_r;
    opened_at_nxt = opened_at_r;
    coil_nxt      = coil_r;
    do_close      = 1'b0;

    case (item.operation)
      dstep_pkg::OP_OPEN: begin
        if (!door_open_r) begin
          door_open_nxt = 1'b1;
          opened_at_nxt = item.now_seconds;
          rem_nxt       = -full_cnt;
          moving_nxt    = 1'b1;
        end
      end
      dstep_pkg::OP_CLOSE: do_close = door_open_r;
      dstep_pkg::OP_TICK: begin
        if (rem_r != 16'sd0) begin
          if (!rem_r[15]) begin
            phase_nxt = phase_r + 3'd1;
            rem_nxt   = rem_r - 16'sd1;
          end else begin
            phase_nxt = phase_r - 3'd1;
            rem_nxt   = rem_r + 16'sd1;
          end
          coil_nxt = dstep_pkg::half_step_coils(phase_nxt);
        end else if (moving_r) begin
          coil_nxt   = 4'h0;
          moving_nxt = 1'b0;
        end
      end
      default: begin
        // wrap-safe elapsed time
        do_close = item.standby && door_open_r &&
                   (elapsed >= {16'd0, cfg.auto_close_seconds});
      end
    endcase

    if (do_close) begin
      rem_nxt       = full_cnt;
      moving_nxt    = 1'b1;
      door_open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      phase_r     <= '0;
      moving_r    <= 1'b0;
      door_open_r <= 1'b0;
      opened_at_r <= '0;
      coil_r      <= '0;
    end else if (fire) begin
      rem_r       <= rem_nxt;
      phase_r     <= phase_nxt;
      moving_r    <= moving_nxt;
      door_open_r <= door_open_nxt;
      opened_at_r <= opened_at_nxt;
      coil_r      <= coil_nxt;
    end
  end

  assign res.coils        = coil_nxt;
  assign res.busy_res     = moving_nxt;
  assign res.door_is_open = door_open_nxt;
  assign res.steps_left   = rem_nxt;

  `DSTEP_ASSERT_IMP(a_rem_implies_moving, rem_r != 16'sd0, moving_r)
  `DSTEP_ASSERT_IMP(a_idle_coils_off, !moving_r, coil_r == 4'h0)
  `DSTEP_ASSERT_NXT(a_door_holds, !fire, $stable(door_open_r))
  `DSTEP_ASSERT_NXT(a_open_stamp, fire && (item.operation == dstep_pkg::OP_OPEN) && !door_open_r, opened_at_r == $past(item.now_seconds))

endmodule

`default_nettype wire

// ===== design/door_stepper_half_step_driver_unit.sv =====
// Top level of the door stepper half-step driver: input register, sequencer
// state, result register and APB configuration. Depends on dstep_pkg,
// dstep_if, dstep_apb and dstep_seq.
//
// One transaction in gives one result out. The block accepts a new item every
// cycle unless the output stalls; each item passes through the input
// register and then the result register. The sequencer state updates as the
// item moves from the input register to the result register, so items see
// the state left by the one before them. Registers are to be written over APB
// only while no items are in flight; the block itself does not enforce this.
`default_nettype none

module door_stepper_half_step_driver_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dstep_in_if.sink                             in_ch,
  dstep_out_if.source                          out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [dstep_pkg::AddrWidth-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  dstep_pkg::cfg_t  cfg;
  dstep_pkg::item_t item_r;
  dstep_pkg::res_t  res, res_r;
  logic             item_vld_r;
  logic             out_vld_r;
  logic             advance;

  assign advance      = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ch.ready) item_vld_r <= in_ch.valid;
      if (advance) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.operation   <= in_ch.operation;
      item_r.now_seconds <= in_ch.now_seconds;
      item_r.standby     <= in_ch.standby;
    end
    if (advance) res_r <= res;
  end

  dstep_apb u_apb (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  dstep_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (advance),
    .item (item_r),
    .cfg  (cfg),
    .res  (res)
  );

  assign out_ch.valid        = out_vld_r;
  assign out_ch.coils        = res_r.coils;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.door_is_open = res_r.door_is_open;
  assign out_ch.steps_left   = res_r.steps_left;

endmodule

`default_nettype wire
